[rtl/bblru_pkg.sv]
// Package for the byte-budget LRU cache core: word types, codes and state enum.
// Used by rtl/byte_budget_lru_cache_core.sv; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bblru_pkg;

    localparam int unsigned MIB_SHIFT   = 20;
    localparam int unsigned HANDLE_BITS = 16;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_EVICTED   = 3'd4,
        ST_CLEARED   = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]             operation;
        logic [30:0]            volume_id;
        logic [30:0]            page_id;
        logic [HANDLE_BITS-1:0] entry_handle;
        logic [30:0]            entry_bytes;
    } req_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [HANDLE_BITS-1:0] result_handle;
        logic [30:0]            result_volume;
        logic [30:0]            result_page;
        logic                   last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_FIND_OLD,
        S_EVICT_SUB,
        S_EVICT_AGE,
        S_FIND_FREE,
        S_PLACE,
        S_CHECK,
        S_TOUCH,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

[rtl/byte_budget_lru_cache_core.sv]
// Byte-budget LRU cache core: fully associative table walked by one shared compare unit.
// Depends on rtl/bblru_pkg.sv.
// A clear is answered from idle; lookups and inserts scan the table, and each eviction
// adds scans of its own. One request at a time; each scan visits one table slot per cycle.
// Reset clears all valid bits and the byte total and sets the budget register to 64 MiB.
`timescale 1ns / 1ps
`default_nettype none
module byte_budget_lru_cache_core #(
    parameter int ENTRIES = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire bblru_pkg::req_t    in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output bblru_pkg::rsp_t         out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [19:0]        cfg_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int HW = bblru_pkg::HANDLE_BITS;

    // Table storage.
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [61:0]          key_mem    [ENTRIES];
    logic [HW-1:0]        handle_mem [ENTRIES];
    logic [30:0]          size_mem   [ENTRIES];
    logic [IW-1:0]        rank_mem   [ENTRIES];

    // Registered read data: one port follows the scan index, one the selected slot.
    logic [61:0]          key_rd_reg;
    logic [IW-1:0]        rank_rd_reg;
    logic [61:0]          slot_key_reg;
    logic [HW-1:0]        slot_handle_reg;
    logic [30:0]          slot_size_reg;
    logic [IW-1:0]        scan_addr;

    logic [47:0]          total_reg, total_next;
    logic [19:0]          budget_reg;
    bblru_pkg::state_t    state_reg, state_next;
    bblru_pkg::req_t      req_reg, req_next;
    logic [IW:0]          idx_reg, idx_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        rank_reg, rank_next;
    logic                 new_gone_reg, new_gone_next;
    logic                 full_evict_reg, full_evict_next;
    bblru_pkg::rsp_t      rsp_reg, rsp_next;
    logic                 out_valid_reg, out_valid_next;

    // Write strobes into the table.
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    logic                 rk_en;
    logic [IW-1:0]        rk_idx;
    logic [IW-1:0]        rk_val;

    logic [IW-1:0]        cur;
    logic                 at_end;
    logic [61:0]          req_key;
    logic [48:0]          limit;

    assign cur       = idx_reg[IW-1:0];
    assign scan_addr = idx_next[IW-1:0];
    assign at_end    = (idx_reg == (IW+1)'(ENTRIES - 1));
    assign req_key   = {req_reg.volume_id, req_reg.page_id};
    assign limit     = {9'd0, budget_reg, 20'd0};

    assign in_stall  = (state_reg != bblru_pkg::S_IDLE) || out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // Control, status and table registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bblru_pkg::S_IDLE;
            valid_reg      <= '0;
            total_reg      <= '0;
            budget_reg     <= 20'd64;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            new_gone_reg   <= 1'b0;
            full_evict_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
            new_gone_reg   <= new_gone_next;
            full_evict_reg <= full_evict_next;
            if (cfg_valid)
            begin
                budget_reg <= cfg_data;
            end
        end
    end

    // Payload registers and table memories. Reads are addressed with the next index and slot,
    // so the data for the current scan index and slot is ready in the register.
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        slot_reg <= slot_next;
        rank_reg <= rank_next;
        rsp_reg  <= rsp_next;
        if (wr_en)
        begin
            key_mem[wr_idx]    <= req_key;
            handle_mem[wr_idx] <= req_reg.entry_handle;
            size_mem[wr_idx]   <= req_reg.entry_bytes;
        end
        if (rk_en)
        begin
            rank_mem[rk_idx] <= rk_val;
        end
        key_rd_reg      <= key_mem[scan_addr];
        rank_rd_reg     <= rank_mem[scan_addr];
        slot_key_reg    <= key_mem[slot_next];
        slot_handle_reg <= handle_mem[slot_next];
        slot_size_reg   <= size_mem[slot_next];
    end

    // Sequencer: one slot is examined per cycle by the shared compare.
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        new_gone_next   = new_gone_reg;
        full_evict_next = full_evict_reg;
        req_next        = req_reg;
        slot_next       = slot_reg;
        rank_next       = rank_reg;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        wr_idx          = slot_reg;
        rk_en           = 1'b0;
        rk_idx          = cur;
        rk_val          = rank_rd_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bblru_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    req_next   = in_data;
                    idx_next   = '0;
                    found_next = 1'b0;
                    count_next = '0;
                    priority if (in_data.operation == bblru_pkg::OP_CLEAR)
                    begin
                        valid_next = '0;
                        total_next = '0;
                        rsp_next   = '{status: bblru_pkg::ST_CLEARED, result_handle: '0,
                                       result_volume: in_data.volume_id,
                                       result_page: in_data.page_id, last: 1'b1};
                        out_valid_next = 1'b1;
                    end
                    else if (in_data.operation == bblru_pkg::OP_NONE)
                    begin
                        state_next = bblru_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = bblru_pkg::S_SEARCH;
                    end
                end
            end
            // Walk all slots: key match and valid count.
            bblru_pkg::S_SEARCH:
            begin
                if (valid_reg[cur])
                begin
                    count_next = count_reg + CW'(1);
                    if (!found_reg && key_rd_reg == req_key)
                    begin
                        found_next = 1'b1;
                        slot_next  = cur;
                        rank_next  = rank_rd_reg;
                    end
                end
                idx_next = idx_reg + (IW+1)'(1);
                if (at_end)
                begin
                    state_next = bblru_pkg::S_DECIDE;
                end
            end
            bblru_pkg::S_DECIDE:
            begin
                idx_next = '0;
                if (!out_valid_reg || !out_stall)
                begin
                    priority if (req_reg.operation == bblru_pkg::OP_LOOKUP)
                    begin
                        if (found_reg)
                        begin
                            state_next = bblru_pkg::S_TOUCH;
                        end
                        else
                        begin
                            rsp_next = '{status: bblru_pkg::ST_MISS, result_handle: '0,
                                         result_volume: req_reg.volume_id,
                                         result_page: req_reg.page_id, last: 1'b1};
                            out_valid_next = 1'b1;
                            state_next     = bblru_pkg::S_IDLE;
                        end
                    end
                    else if (found_reg)
                    begin
                        rsp_next = '{status: bblru_pkg::ST_DUPLICATE, result_handle: '0,
                                     result_volume: req_reg.volume_id,
                                     result_page: req_reg.page_id, last: 1'b1};
                        out_valid_next = 1'b1;
                        state_next     = bblru_pkg::S_IDLE;
                    end
                    else if (count_reg >= CW'(ENTRIES))
                    begin
                        full_evict_next = 1'b1;
                        new_gone_next   = 1'b0;
                        state_next      = bblru_pkg::S_FIND_OLD;
                    end
                    else
                    begin
                        full_evict_next = 1'b0;
                        state_next      = bblru_pkg::S_FIND_FREE;
                    end
                end
            end
            // Hit: age entries newer than the hit, then make it most recent.
            bblru_pkg::S_TOUCH:
            begin
                if (valid_reg[cur] && rank_rd_reg > rank_reg)
                begin
                    rk_en  = 1'b1;
                    rk_val = rank_rd_reg - IW'(1);
                end
                idx_next = idx_reg + (IW+1)'(1);
                if (at_end)
                begin
                    state_next = bblru_pkg::S_OUT;
                end
            end
            bblru_pkg::S_OUT:
            begin
                rk_en  = 1'b1;
                rk_idx = slot_reg;
                rk_val = IW'(count_reg - CW'(1));
                if (!out_valid_reg || !out_stall)
                begin
                    rsp_next = '{status: bblru_pkg::ST_HIT,
                                 result_handle: slot_handle_reg,
                                 result_volume: req_reg.volume_id,
                                 result_page: req_reg.page_id, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = bblru_pkg::S_IDLE;
                end
            end
            // Find the least recent valid slot.
            bblru_pkg::S_FIND_OLD:
            begin
                if (valid_reg[cur] && rank_rd_reg == '0)
                begin
                    slot_next  = cur;
                    idx_next   = '0;
                    state_next = bblru_pkg::S_EVICT_SUB;
                end
                else
                begin
                    idx_next = idx_reg + (IW+1)'(1);
                    if (at_end)
                    begin
                        state_next = bblru_pkg::S_CHECK;
                    end
                end
            end
            // Drop the slot, subtract its size and report it.
            bblru_pkg::S_EVICT_SUB:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    valid_next[slot_reg] = 1'b0;
                    total_next = total_reg - {17'd0, slot_size_reg};
                    count_next = count_reg - CW'(1);
                    if (!full_evict_reg && slot_reg == rank_reg)
                    begin
                        new_gone_next = 1'b1;
                    end
                    rsp_next = '{status: bblru_pkg::ST_EVICTED,
                                 result_handle: slot_handle_reg,
                                 result_volume: slot_key_reg[61:31],
                                 result_page: slot_key_reg[30:0],
                                 last: (!full_evict_reg && slot_reg == rank_reg)};
                    out_valid_next = 1'b1;
                    idx_next       = '0;
                    state_next     = bblru_pkg::S_EVICT_AGE;
                end
            end
            bblru_pkg::S_EVICT_AGE:
            begin
                if (valid_reg[cur] && rank_rd_reg != '0)
                begin
                    rk_en  = 1'b1;
                    rk_val = rank_rd_reg - IW'(1);
                end
                idx_next = idx_reg + (IW+1)'(1);
                if (at_end)
                begin
                    idx_next = '0;
                    if (full_evict_reg)
                    begin
                        full_evict_next = 1'b0;
                        state_next      = bblru_pkg::S_FIND_FREE;
                    end
                    else
                    begin
                        state_next = bblru_pkg::S_CHECK;
                    end
                end
            end
            bblru_pkg::S_FIND_FREE:
            begin
                if (!valid_reg[cur])
                begin
                    slot_next  = cur;
                    rank_next  = cur;
                    state_next = bblru_pkg::S_PLACE;
                end
                else
                begin
                    idx_next = idx_reg + (IW+1)'(1);
                end
            end
            // Write the new entry as most recent.
            bblru_pkg::S_PLACE:
            begin
                wr_en  = 1'b1;
                wr_idx = slot_reg;
                rk_en  = 1'b1;
                rk_idx = slot_reg;
                rk_val = IW'(count_reg);
                valid_next[slot_reg] = 1'b1;
                count_next    = count_reg + CW'(1);
                total_next    = total_reg + {17'd0, req_reg.entry_bytes};
                new_gone_next = 1'b0;
                idx_next      = '0;
                state_next    = bblru_pkg::S_CHECK;
            end
            // Evict while over budget, then report the insert if it survived.
            bblru_pkg::S_CHECK:
            begin
                idx_next = '0;
                if (new_gone_reg)
                begin
                    state_next = bblru_pkg::S_IDLE;
                end
                else if ({1'b0, total_reg} > limit && count_reg != '0)
                begin
                    state_next = bblru_pkg::S_FIND_OLD;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    rsp_next = '{status: bblru_pkg::ST_INSERTED,
                                 result_handle: req_reg.entry_handle,
                                 result_volume: req_reg.volume_id,
                                 result_page: req_reg.page_id, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = bblru_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bblru_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[verif/byte_budget_lru_cache_checker.sv]
// Checker for the byte-budget LRU cache core: watches the request and response channels,
// keeps its own copy of the cache table and compares every response word. Uses bblru_pkg.
`timescale 1ns / 1ps
module byte_budget_lru_cache_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  bblru_pkg::req_t   in_data,
    input  logic              out_valid,
    input  logic              out_stall,
    input  bblru_pkg::rsp_t   out_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [19:0]       cfg_data,
    output int                fail_count,
    output int                pending_count,
    output int                resp_seen,
    output int                evict_seen,
    output int                hit_seen
);
    localparam int SLOTS = 32;

    // Shadow copy of the cache table and the budget.
    logic [19:0] budget_mb;
    logic        slot_valid [SLOTS];
    logic [61:0] slot_key   [SLOTS];
    logic [15:0] slot_handle[SLOTS];
    logic [30:0] slot_bytes [SLOTS];
    int          slot_age   [SLOTS];
    logic [47:0] bytes_held;

    bblru_pkg::rsp_t expected_rsp[$];

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i]) n++;
        return n;
    endfunction

    function automatic int find_slot(logic [61:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_key[i] == key) return i;
        return -1;
    endfunction

    // Drop the least recent entry and queue its eviction word.
    function automatic bit drop_oldest();
        int s;
        bblru_pkg::rsp_t r;
        s = -1;
        for (int i = 0; i < SLOTS; i++)
            if (s < 0 && slot_valid[i] && slot_age[i] == 0) s = i;
        if (s < 0) return 0;
        slot_valid[s] = 1'b0;
        bytes_held = bytes_held - {17'd0, slot_bytes[s]};
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_age[i] > 0) slot_age[i]--;
        r.status = bblru_pkg::ST_EVICTED;
        r.result_handle = slot_handle[s];
        r.result_volume = slot_key[s][61:31];
        r.result_page = slot_key[s][30:0];
        r.last = 1'b0;
        expected_rsp.push_back(r);
        return 1;
    endfunction

    // Work out the response words of one accepted request.
    function automatic void cache_request(bblru_pkg::req_t q);
        logic [61:0] key;
        logic [47:0] limit;
        int s, first, r;
        bblru_pkg::rsp_t w;
        key = {q.volume_id, q.page_id};
        first = expected_rsp.size();
        w.result_volume = q.volume_id;
        w.result_page = q.page_id;
        w.result_handle = '0;
        w.last = 1'b0;
        limit = {28'd0, budget_mb} << bblru_pkg::MIB_SHIFT;
        if (q.operation == bblru_pkg::OP_LOOKUP) begin
            s = find_slot(key);
            if (s >= 0) begin
                r = slot_age[s];
                for (int i = 0; i < SLOTS; i++)
                    if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
                slot_age[s] = live_count() - 1;
                w.status = bblru_pkg::ST_HIT;
                w.result_handle = slot_handle[s];
            end else begin
                w.status = bblru_pkg::ST_MISS;
            end
            expected_rsp.push_back(w);
        end else if (q.operation == bblru_pkg::OP_INSERT) begin
            if (find_slot(key) >= 0) begin
                w.status = bblru_pkg::ST_DUPLICATE;
                expected_rsp.push_back(w);
            end else begin
                if (live_count() >= SLOTS) void'(drop_oldest());
                s = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && !slot_valid[i]) s = i;
                slot_age[s] = live_count();
                slot_valid[s] = 1'b1;
                slot_key[s] = key;
                slot_handle[s] = q.entry_handle;
                slot_bytes[s] = q.entry_bytes;
                bytes_held = bytes_held + {17'd0, q.entry_bytes};
                while (bytes_held > limit)
                    if (!drop_oldest()) break;
                if (slot_valid[s]) begin
                    w.status = bblru_pkg::ST_INSERTED;
                    w.result_handle = q.entry_handle;
                    expected_rsp.push_back(w);
                end
            end
        end else if (q.operation == bblru_pkg::OP_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
            bytes_held = '0;
            w.status = bblru_pkg::ST_CLEARED;
            expected_rsp.push_back(w);
        end
        // Mark the final word of this request.
        if (expected_rsp.size() > first)
            expected_rsp[expected_rsp.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        bblru_pkg::rsp_t e;
        if (!rst_n) begin
            budget_mb <= 20'd64;
            bytes_held = '0;
            for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
            expected_rsp.delete();
            fail_count <= 0;
            pending_count <= 0;
            resp_seen <= 0;
            evict_seen <= 0;
            hit_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) budget_mb <= cfg_data;
            // Compare an accepted response word with the oldest expectation.
            if (out_valid && !out_stall) begin
                resp_seen <= resp_seen + 1;
                if (out_data.status == bblru_pkg::ST_EVICTED) evict_seen <= evict_seen + 1;
                if (out_data.status == bblru_pkg::ST_HIT) hit_seen <= hit_seen + 1;
                if (expected_rsp.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected response word %h", out_data);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_rsp[0];
                    expected_rsp.delete(0);
                    if (e !== out_data) begin
                        if (fail_count < 10)
                            $display({"mismatch: expected st=%0d h=%h v=%h p=%h l=%b, ",
                                      "got st=%0d h=%h v=%h p=%h l=%b"},
                                e.status, e.result_handle, e.result_volume, e.result_page,
                                e.last, out_data.status, out_data.result_handle,
                                out_data.result_volume, out_data.result_page, out_data.last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall) cache_request(in_data);
            pending_count <= expected_rsp.size();
        end
    end

    final begin
        if (expected_rsp.size() != 0)
            $display("%0d response words never arrived", expected_rsp.size());
    end
endmodule

[verif/byte_budget_lru_cache_core_tb.sv]
// Testbench top for the byte-budget LRU cache core: drives requests and budget writes,
// stalls responses, and gives the verdict. Depends on bblru_pkg and the checker module.
`timescale 1ns / 1ps
module byte_budget_lru_cache_core_tb;

    localparam int IDLE_LIMIT = 20000;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    bblru_pkg::req_t in_data;
    logic            out_valid;
    logic            out_stall;
    bblru_pkg::rsp_t out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [19:0]     cfg_data;
    int              fail_count, pending_count, resp_seen, evict_seen, hit_seen;
    int              quiet_cycles;
    int              sent;
    bit              stall_mode;

    // Small key pool so that hits, duplicates and evictions are common.
    logic [30:0] vol_pool[8];
    logic [30:0] page_pool[8];

    byte_budget_lru_cache_core #(.ENTRIES(32)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    byte_budget_lru_cache_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .resp_seen(resp_seen), .evict_seen(evict_seen), .hit_seen(hit_seen)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Receiver stall pattern: phases of light and heavy stalling.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_mode <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
            if (stall_mode) out_stall <= ($urandom_range(0, 3) != 0);
            else out_stall <= ($urandom_range(0, 7) == 0);
        end
    end

    // Watchdog on cycles in which no word is accepted anywhere.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("byte_budget_lru_cache_core_tb: errors");
            $finish;
        end
    end

    // Send one request word and hold it until accepted.
    task automatic send_req(logic [1:0] op, logic [30:0] vol, logic [30:0] pg,
                            logic [15:0] h, logic [30:0] nbytes);
        in_data <= '{operation: op, volume_id: vol, page_id: pg,
                     entry_handle: h, entry_bytes: nbytes};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
    endtask

    // Wait until every expected word has come, then let the core settle.
    task automatic drain();
        go_idle();
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_budget(logic [19:0] mb);
        cfg_data <= mb;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random request, mostly well-formed over the key pool.
    task automatic random_req(int big_sizes);
        logic [1:0]  op;
        logic [30:0] vol, pg, nbytes;
        int          pick;
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? bblru_pkg::OP_LOOKUP : (pick < 95) ? bblru_pkg::OP_INSERT :
             (pick < 98) ? bblru_pkg::OP_CLEAR : bblru_pkg::OP_NONE;
        if ($urandom_range(0, 9) == 0) begin
            vol = 31'($urandom);
            pg = 31'($urandom);
        end else begin
            vol = vol_pool[$urandom_range(0, 7)];
            pg = page_pool[$urandom_range(0, 7)];
        end
        nbytes = big_sizes ? 31'($urandom) : 31'($urandom_range(0, 3 << 20));
        send_req(op, vol, pg, 16'($urandom), nbytes);
        if (op == bblru_pkg::OP_NONE) sent--;
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        quiet_cycles = 0;
        sent = 0;
        for (int i = 0; i < 8; i++) begin
            vol_pool[i] = 31'($urandom);
            page_pool[i] = 31'($urandom);
        end
        vol_pool[0] = '0;
        page_pool[0] = '0;
        vol_pool[1] = '1;
        page_pool[1] = '1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, duplicates, hits, clear, unused code.
        send_req(bblru_pkg::OP_LOOKUP, '0, '0, '0, '0);
        send_req(bblru_pkg::OP_INSERT, '0, '0, 16'hFFFF, '0);
        send_req(bblru_pkg::OP_INSERT, '1, '1, 16'h0000, 31'd1 << 20);
        send_req(bblru_pkg::OP_INSERT, '0, '0, 16'h1234, 31'd5);
        send_req(bblru_pkg::OP_LOOKUP, '0, '0, '0, '0);
        send_req(bblru_pkg::OP_LOOKUP, '1, '1, '1, '1);
        send_req(bblru_pkg::OP_NONE, '1, '1, '1, '1);
        send_req(bblru_pkg::OP_INSERT, 31'h5555_5555, 31'h2AAA_AAAA, 16'hA5A5, '1);
        send_req(bblru_pkg::OP_CLEAR, '1, '0, '1, '1);
        send_req(bblru_pkg::OP_LOOKUP, '0, '0, '0, '0);
        // Fill past the entry bound so the full-table eviction fires.
        for (int i = 0; i < 34; i++)
            send_req(bblru_pkg::OP_INSERT, 31'(i), 31'(i * 3), 16'(i), 31'd100);
        drain();

        // Zero budget: only zero-byte entries stay.
        write_budget(20'd0);
        send_req(bblru_pkg::OP_INSERT, 31'd7, 31'd7, 16'd7, 31'd0);
        send_req(bblru_pkg::OP_INSERT, 31'd8, 31'd8, 16'd8, 31'd1);
        send_req(bblru_pkg::OP_LOOKUP, 31'd7, 31'd7, '0, '0);
        drain();

        // Random phases over several budgets, the largest among them.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_budget(20'd4);
                1: write_budget(20'd1);
                2: write_budget('1);
                default: write_budget(20'd64);
            endcase
            for (int n = 0; n < 95; ) begin
                for (int b = $urandom_range(1, 12); b > 0 && n < 95; b--) begin
                    random_req(ph == 2);
                    n++;
                end
                go_idle();
                repeat ($urandom_range(0, 6)) @(posedge clk);
                if ($urandom_range(0, 30) == 0) drain();
            end
            drain();
        end

        $display("sent %0d requests, checked %0d response words (%0d hits, %0d evictions)",
            sent, resp_seen, hit_seen, evict_seen);
        $display("budgets covered: reset 64, 0, 1, 4 and max MiB, with random stalls");
        if (fail_count == 0 && pending_count == 0)
            $display("byte_budget_lru_cache_core_tb: clean");
        else
            $display("byte_budget_lru_cache_core_tb: errors");
        $finish;
    end
endmodule
